// ----- hw/rtl/base64_vigenere_cipher_macros.svh -----
// Assertion macros used by the checker of this block.
`ifndef BASE64_VIGENERE_CIPHER_MACROS_SVH
`define BASE64_VIGENERE_CIPHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64VC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64VC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/b64vc_pkg.sv -----
package b64vc_pkg;

	// Fixed widths of the register file and of the key length.
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 64;
	localparam int LenW     = 6;

	// Register indexes.
	localparam logic [CfgIdxW-1:0] RegMode       = 3'd0;
	localparam logic [CfgIdxW-1:0] RegKeyLength  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegKeyBytes0  = 3'd2;

	// Key byte after reset is 'A' in the first eight positions.
	localparam logic [7:0] KeyResetByte = 8'h41;
	localparam int         KeyResetBytes = 8;

	// Marker for a byte that is not in the alphabet.
	localparam logic [6:0] NoSymbol = 7'd64;

	// Which result the output register takes.
	typedef enum logic [2:0] {
		OutNone,
		OutInPass,
		OutInErr,
		OutHit,
		OutMiss
	} out_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     take;
		logic     step;
		out_sel_t out_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_sym;
		logic len_zero;
		logic key_hit;
		logic last_try;
	} status_t;

	// Alphabet index of a byte, or NoSymbol when the byte is outside it.
	function automatic logic [6:0] symbol_index(input logic [7:0] c);
		logic [6:0] idx;
		case (c) inside
			[8'h41:8'h5A]: idx = 7'(c - 8'h41);
			[8'h61:8'h7A]: idx = 7'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: idx = 7'(c - 8'h30 + 8'd52);
			8'h2B:         idx = 7'd62;
			8'h2F:         idx = 7'd63;
			default:       idx = NoSymbol;
		endcase
		return idx;
	endfunction

	// Character of an alphabet index.
	function automatic logic [7:0] symbol_char(input logic [5:0] i);
		logic [7:0] c;
		if (i < 6'd26) begin
			c = 8'h41 + {2'b00, i};
		end else if (i < 6'd52) begin
			c = 8'h61 + {2'b00, i} - 8'd26;
		end else if (i < 6'd62) begin
			c = 8'h30 + {2'b00, i} - 8'd52;
		end else if (i == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/b64vc_datapath.sv -----
module b64vc_datapath #(
	parameter int KEY_MAX = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [b64vc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [b64vc_pkg::CfgDataW-1:0]    cfg_data,
	input  logic [7:0]                        in_char,
	input  logic                              start_req,
	input  b64vc_pkg::cmd_t                   cmd,
	output b64vc_pkg::status_t                status,
	output logic [7:0]                        out_char,
	output logic                              key_error
);

	localparam int PosW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int LenW = b64vc_pkg::LenW;

	logic             mode_q;
	logic [LenW-1:0]  key_length_q;
	logic [7:0]       key_q [KEY_MAX];
	logic [PosW-1:0]  key_position_q;

	logic [7:0]       char_q;
	logic [5:0]       sym_q;
	logic [PosW-1:0]  pos_q;
	logic [LenW-1:0]  cnt_q;
	logic [7:0]       out_char_q;
	logic             key_error_q;

	logic [LenW-1:0]  len;
	logic [6:0]       in_idx;
	logic [PosW-1:0]  kp_start;
	logic [PosW-1:0]  pos_init;
	logic [LenW-1:0]  pos_inc;
	logic [PosW-1:0]  pos_next;
	logic [6:0]       key_idx;
	logic [5:0]       code_idx;

	// Configuration registers; bytes beyond the key store are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			key_length_q <= LenW'(1);
			for (int b = 0; b < KEY_MAX; b++) begin
				key_q[b] <= (b < b64vc_pkg::KeyResetBytes) ? b64vc_pkg::KeyResetByte : 8'h00;
			end
		end else if (cfg_we) begin
			if (cfg_index == b64vc_pkg::RegMode) begin
				mode_q <= cfg_data[0];
			end
			if (cfg_index == b64vc_pkg::RegKeyLength) begin
				key_length_q <= cfg_data[LenW-1:0];
			end
			for (int b = 0; b < KEY_MAX; b++) begin
				if (cfg_index == b64vc_pkg::CfgIdxW'(b64vc_pkg::RegKeyBytes0 + (b >> 3))) begin
					key_q[b] <= cfg_data[(b % 8) * 8 +: 8];
				end
			end
		end
	end

	// Key length in use, limited to the size of the key store.
	assign len = (key_length_q > LenW'(KEY_MAX)) ? LenW'(KEY_MAX) : key_length_q;

	// First key position to try for a new item.
	assign in_idx   = b64vc_pkg::symbol_index(in_char);
	assign kp_start = start_req ? '0 : key_position_q;
	assign pos_init = (LenW'(kp_start) >= len) ? '0 : kp_start;

	// Search pointer steps forward and wraps at the key length.
	assign pos_inc  = LenW'(pos_q) + LenW'(1);
	assign pos_next = (pos_inc >= len) ? '0 : pos_inc[PosW-1:0];

	// Key character under the search pointer and the coded symbol.
	assign key_idx  = b64vc_pkg::symbol_index(key_q[pos_q]);
	assign code_idx = mode_q ? (sym_q - key_idx[5:0]) : (sym_q + key_idx[5:0]);

	assign status.in_is_sym = (in_idx != b64vc_pkg::NoSymbol);
	assign status.len_zero  = (len == '0);
	assign status.key_hit   = (key_idx != b64vc_pkg::NoSymbol);
	assign status.last_try  = ((cnt_q + LenW'(1)) == len);

	// Key position register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_position_q <= '0;
		end else if (cmd.take) begin
			if (start_req) begin
				key_position_q <= '0;
			end
		end else if (cmd.out_sel == b64vc_pkg::OutHit) begin
			key_position_q <= pos_next;
		end
	end

	// Search registers carry no control meaning and need no reset.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			char_q <= in_char;
			sym_q  <= in_idx[5:0];
			pos_q  <= pos_init;
			cnt_q  <= '0;
		end else if (cmd.step) begin
			pos_q <= pos_next;
			cnt_q <= cnt_q + LenW'(1);
		end
	end

	// Output register loads whichever result the controller selects.
	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			b64vc_pkg::OutInPass: begin
				out_char_q  <= in_char;
				key_error_q <= 1'b0;
			end
			b64vc_pkg::OutInErr: begin
				out_char_q  <= in_char;
				key_error_q <= 1'b1;
			end
			b64vc_pkg::OutHit: begin
				out_char_q  <= b64vc_pkg::symbol_char(code_idx);
				key_error_q <= 1'b0;
			end
			b64vc_pkg::OutMiss: begin
				out_char_q  <= char_q;
				key_error_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_char  = out_char_q;
	assign key_error = key_error_q;

endmodule

// ----- hw/rtl/b64vc_ctrl.sv -----
module b64vc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  b64vc_pkg::status_t status,
	output b64vc_pkg::cmd_t    cmd
);

	typedef enum logic {
		StIdle,
		StSearch
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   accept;

	// A new item is taken only when idle and the output slot is free or emptying.
	assign in_ready = (state_q == StIdle) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// Next state and commands to the datapath.
	always_comb begin
		state_next  = state_q;
		cmd.take    = 1'b0;
		cmd.step    = 1'b0;
		cmd.out_sel = b64vc_pkg::OutNone;
		case (state_q)
			StIdle: begin
				if (accept) begin
					cmd.take = 1'b1;
					if (!status.in_is_sym) begin
						cmd.out_sel = b64vc_pkg::OutInPass;
					end else if (status.len_zero) begin
						cmd.out_sel = b64vc_pkg::OutInErr;
					end else begin
						state_next = StSearch;
					end
				end
			end
			StSearch: begin
				cmd.step = 1'b1;
				if (status.key_hit) begin
					cmd.out_sel = b64vc_pkg::OutHit;
					state_next  = StIdle;
				end else if (status.last_try) begin
					cmd.out_sel = b64vc_pkg::OutMiss;
					state_next  = StIdle;
				end
			end
			default: begin
				state_next = StIdle;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_sel != b64vc_pkg::OutNone) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/base64_vigenere_cipher.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_char, start_req
// out       out_valid / out_ready  out_char, key_error
// cfg       cfg_we                 cfg_index, cfg_data
//
// A byte outside the alphabet, or one met with a zero key length, gives its result
// in the cycle after it is taken. For an alphabet byte the search pointer visits
// one key byte per cycle, from 1 up to the key length in use, until one is in the
// alphabet or all have been tried. One item is in flight at a time; the output
// register frees the input side as soon as the result is taken. Reset is
// asynchronous and resets control state, key position and configuration registers.
module base64_vigenere_cipher #(
	parameter int KEY_MAX = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [b64vc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [b64vc_pkg::CfgDataW-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     in_char,
	input  logic                           start_req,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_char,
	output logic                           key_error
);

	b64vc_pkg::cmd_t    cmd;
	b64vc_pkg::status_t status;

	// Sequencer for the key search.
	b64vc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Key store, search pointer and symbol arithmetic.
	b64vc_datapath #(
		.KEY_MAX (KEY_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_char   (in_char),
		.start_req (start_req),
		.cmd       (cmd),
		.status    (status),
		.out_char  (out_char),
		.key_error (key_error)
	);

endmodule

// ----- hw/rtl/b64vc_checker.sv -----
`include "base64_vigenere_cipher_macros.svh"

module b64vc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [b64vc_pkg::CfgIdxW-1:0]  cfg_index,
	input logic [b64vc_pkg::CfgDataW-1:0] cfg_data,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [7:0]                     in_char,
	input logic                           start_req,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [7:0]                     out_char,
	input logic                           key_error
);

	logic in_take;
	logic in_is_sym;
	logic out_is_sym;

	assign in_take    = in_valid && in_ready;
	assign in_is_sym  = (b64vc_pkg::symbol_index(in_char) != b64vc_pkg::NoSymbol);
	assign out_is_sym = (b64vc_pkg::symbol_index(out_char) != b64vc_pkg::NoSymbol);

	// A waiting result holds until it is taken.
	`B64VC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(key_error), "result changed while stalled")

	// A byte outside the alphabet comes out unchanged in the next cycle.
	`B64VC_ASSERT_NEXT(a_pass, in_take && !in_is_sym, out_valid && !key_error && (out_char == $past(in_char)), "non-alphabet byte not passed through")

	// An alphabet byte either starts a key search, during which no item is taken,
	// or meets a zero key length and is flagged at once.
	`B64VC_ASSERT_NEXT(a_search_busy, in_take && in_is_sym, !in_ready || (out_valid && key_error), "item taken during key search")

	// A key error is only reported for an alphabet byte.
	`B64VC_ASSERT_SAME(a_err_sym, out_valid && key_error, out_is_sym, "key error on non-alphabet byte")

endmodule

bind base64_vigenere_cipher b64vc_checker u_b64vc_checker (.*);

// ----- dv/base64_vigenere_cipher_tb.sv -----
module base64_vigenere_cipher_tb;

	import b64vc_pkg::*;

	localparam int KEY_MAX     = 32;
	// Quiet cycles allowed before the run is declared hung: enough for the longest key
	// search, plus the longest stall on either side and the settle pause.
	localparam int STALL_LIMIT = 2000;
	// Cycles to let pass once nothing is outstanding, covering the longest key search.
	localparam int SETTLE      = KEY_MAX + 8;

	// Register indexes past the last key word; writes to them must be ignored.
	localparam logic [CfgIdxW-1:0] RegSpare0 = RegKeyBytes0 + 3'd4;
	localparam logic [CfgIdxW-1:0] RegSpare1 = RegKeyBytes0 + 3'd5;

	// The 64-symbol alphabet, symbol 0 first.
	localparam logic [0:63][7:0] ALPHA_CHARS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       err;
	} cipher_out_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [7:0]          in_char   = 8'h00;
	logic                start_req = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          out_char;
	logic                key_error;

	// Cipher state as the block should hold it.
	logic        cipher_decrypt;
	logic [5:0]  cipher_key_len;
	logic [63:0] cipher_key_words [4];
	logic [4:0]  cipher_key_pos;

	cipher_out_t predicted_bytes [$];
	int          byte_mismatches = 0;
	int          bytes_sent      = 0;
	int          key_settings    = 0;
	int          key_errors_seen = 0;
	int          unchanged_seen  = 0;
	bit          throttle_on     = 1'b1;
	int          rx_left         = 0;

	base64_vigenere_cipher #(
		.KEY_MAX(KEY_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_char  (in_char),
		.start_req(start_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char (out_char),
		.key_error(key_error)
	);

	always #4 clk = ~clk;

	// Alphabet position of a byte, or -1 when the byte is outside the alphabet.
	function automatic int alpha_pos(input logic [7:0] c);
		int i;
		for (i = 0; i < 64; i++) begin
			if (ALPHA_CHARS[i] == c) return i;
		end
		return -1;
	endfunction

	function automatic logic [7:0] key_byte_at(input int p);
		return cipher_key_words[(p & 31) / 8][(p % 8) * 8 +: 8];
	endfunction

	function automatic void cipher_reset();
		cipher_decrypt      = 1'b0;
		cipher_key_len      = 6'd1;
		cipher_key_words[0] = {8{8'h41}};
		cipher_key_words[1] = '0;
		cipher_key_words[2] = '0;
		cipher_key_words[3] = '0;
		cipher_key_pos      = '0;
	endfunction

	function automatic void cipher_config(input logic [CfgIdxW-1:0] idx,
			input logic [63:0] d);
		if (idx == RegMode) begin
			cipher_decrypt = d[0];
		end else if (idx == RegKeyLength) begin
			cipher_key_len = d[5:0];
		end else if (idx >= RegKeyBytes0 && idx < RegSpare0) begin
			cipher_key_words[int'(idx - RegKeyBytes0)] = d;
		end
	endfunction

	// Works out the result of one byte and moves the key position on.
	function automatic cipher_out_t cipher_predict(input logic [7:0] c, input logic first);
		cipher_out_t r;
		int          sym, ksym, len, p, tries;
		bit          hit;
		if (first) cipher_key_pos = '0;
		r.ch  = c;
		r.err = 1'b0;
		sym   = alpha_pos(c);
		if (sym < 0) return r;
		len  = (cipher_key_len > KEY_MAX) ? KEY_MAX : int'(cipher_key_len);
		p    = (int'(cipher_key_pos) >= len) ? 0 : int'(cipher_key_pos);
		hit  = 1'b0;
		ksym = 0;
		// Search forward for a key byte inside the alphabet, wrapping at the key length.
		for (tries = 0; tries < len && !hit; tries++) begin
			ksym = alpha_pos(key_byte_at(p));
			if (ksym >= 0) begin
				hit = 1'b1;
			end else begin
				p = (p + 1 >= len) ? 0 : p + 1;
			end
		end
		if (!hit) begin
			r.err = 1'b1;
			return r;
		end
		sym  = cipher_decrypt ? ((sym - ksym) & 63) : ((sym + ksym) & 63);
		r.ch = ALPHA_CHARS[sym];
		cipher_key_pos = 5'((p + 1 >= len) ? 0 : p + 1);
		return r;
	endfunction

	function automatic logic [255:0] pack_key(input string s);
		logic [255:0] r;
		int           i;
		r = '0;
		for (i = 0; i < s.len() && i < 32; i++) r[i * 8 +: 8] = s[i];
		return r;
	endfunction

	function automatic logic [7:0] rand_text_byte();
		if ($urandom_range(0, 3) != 0) return ALPHA_CHARS[$urandom_range(0, 63)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		cipher_config(idx, data);
	endtask

	task automatic load_key(input logic [255:0] key_bytes, input logic [63:0] len_word);
		int w;
		for (w = 0; w < 4; w++) write_reg(RegKeyBytes0 + 3'(w), key_bytes[w * 64 +: 64]);
		write_reg(RegKeyLength, len_word);
		key_settings++;
	endtask

	// Offers one byte, with a random gap before it while throttling, and records
	// the expected result once the block takes it.
	task automatic send_byte(input logic [7:0] c, input logic first);
		int gap;
		@(negedge clk);
		if (throttle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		in_char   <= c;
		start_req <= first;
		do @(posedge clk); while (!in_ready);
		predicted_bytes.push_back(cipher_predict(c, first));
		bytes_sent++;
	endtask

	// Stops offering bytes and waits until the block is idle again.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predicted_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic randomise_key_setup();
		logic [255:0] kb;
		logic [63:0]  lw;
		logic [5:0]   len;
		bit           sparse;
		int           i;
		sparse = ($urandom_range(0, 3) == 0);
		// A sparse key is mostly bytes outside the alphabet, so the search runs long.
		for (i = 0; i < 32; i++) begin
			if (sparse ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0)) begin
				kb[i * 8 +: 8] = 8'($urandom_range(0, 255));
			end else begin
				kb[i * 8 +: 8] = ALPHA_CHARS[$urandom_range(0, 63)];
			end
		end
		case ($urandom_range(0, 9))
			0: begin
				len = 6'd1;
			end
			1: begin
				len = 6'd32;
			end
			2: begin
				len = 6'd0;
			end
			3: begin
				len = 6'($urandom_range(33, 63));
			end
			default: begin
				len = 6'($urandom_range(2, 31));
			end
		endcase
		lw      = {$urandom, $urandom};
		lw[5:0] = len;
		write_reg(RegMode, {$urandom, $urandom});
		load_key(kb, lw);
	endtask

	// Out-of-reset key of all 'A' must leave every byte unchanged.
	task automatic test_reset_key();
		send_byte("A", 1'b1);
		send_byte("z", 1'b0);
	endtask

	// Each alphabet boundary and its neighbours but the byte after '+', in decrypt mode.
	task automatic test_alphabet_edges();
		logic [7:0] edge_bytes [17] = '{"A", 8'h40, "Z", 8'h5B, "a", 8'h60, "z", 8'h7B,
			"0", 8'h3A, "9", "+", 8'h2A, "/", 8'h2E, 8'h00, 8'hFF};
		int i;
		drain();
		write_reg(RegMode, 64'd1);
		load_key(pack_key("Zb9+/"), 64'd5);
		for (i = 0; i < 17; i++) send_byte(edge_bytes[i], i == 0);
	endtask

	task automatic test_key_corners();
		drain();
		write_reg(RegMode, 64'd0);
		// A key with no alphabet byte flags an error, but only on alphabet text.
		load_key({256{1'b1}}, 64'd32);
		send_byte("Q", 1'b1);
		send_byte("-", 1'b0);
		// A zero key length behaves as a key with no alphabet byte.
		drain();
		load_key(pack_key("ABC"), 64'd0);
		send_byte("x", 1'b0);
		// An oversized length saturates; only the last key byte is usable.
		drain();
		load_key({8'h42, 248'h0}, {64{1'b1}});
		send_byte("A", 1'b1);
		send_byte("9", 1'b0);
		// Zero key bytes are skipped.
		drain();
		load_key({192'h0, 64'h4847_4645_4400_0041}, 64'd8);
		send_byte("A", 1'b1);
		send_byte("A", 1'b0);
		send_byte("A", 1'b0);
		// Shrinking the key under the current position restarts the search at byte 0,
		// and writes past the last register change nothing.
		drain();
		write_reg(RegKeyLength, 64'd3);
		write_reg(RegSpare0, {64{1'b1}});
		write_reg(RegSpare1, {$urandom, $urandom});
		send_byte("A", 1'b0);
		send_byte("A", 1'b0);
	endtask

	// Random text over a series of random key setups, with idling on both sides.
	task automatic test_random_traffic(input int setups, input int per_setup);
		int s, i;
		for (s = 0; s < setups; s++) begin
			drain();
			randomise_key_setup();
			for (i = 0; i < per_setup; i++) begin
				send_byte(rand_text_byte(), $urandom_range(0, 15) == 0);
			end
		end
	endtask

	// Back-to-back traffic with the result side always ready.
	task automatic test_full_rate(input int count);
		int i;
		drain();
		throttle_on = 1'b0;
		randomise_key_setup();
		for (i = 0; i < count; i++) send_byte(rand_text_byte(), $urandom_range(0, 15) == 0);
	endtask

	// Result side: runs of ready and bursts of stall while throttling.
	always @(negedge clk) begin
		if (!throttle_on) begin
			out_ready <= 1'b1;
		end else if (rx_left > 0) begin
			rx_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			rx_left = $urandom_range(1, 11);
		end else begin
			out_ready <= 1'b1;
			rx_left = $urandom_range(1, 20);
		end
	end

	// Compare each returned item with the oldest expected one.
	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (key_error) key_errors_seen++;
			if (predicted_bytes.size() == 0) begin
				if (byte_mismatches < 10) begin
					$display("Unexpected item: out_char %h key_error %b", out_char, key_error);
				end
				byte_mismatches++;
			end else begin
				want = predicted_bytes.pop_front();
				if (!want.err && alpha_pos(want.ch) < 0) unchanged_seen++;
				if (out_char !== want.ch || key_error !== want.err) begin
					if (byte_mismatches < 10) begin
						$display("Mismatch: out_char exp %h got %h, key_error exp %b got %b",
							want.ch, out_char, want.err, key_error);
					end
					byte_mismatches++;
				end
			end
		end
	end

	// Ends the run if no handshake or register write happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Timeout: no activity for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		cipher_reset();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_key();
		test_alphabet_edges();
		test_key_corners();
		test_random_traffic(6, 140);
		test_full_rate(160);
		drain();

		$display("Sent %0d bytes under %0d key setups in both modes.", bytes_sent, key_settings);
		$display("Seen %0d key errors and %0d bytes outside the alphabet passed through.",
			key_errors_seen, unchanged_seen);
		if (byte_mismatches == 0 && predicted_bytes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
